[hdl/sida_pkg.sv]
// ----------------------------------------------------------------------------
// sida_pkg
// Shared widths, character codes, pipeline types and the shift-and-add-3
// step used by the binary to BCD stages of signed_int_to_decimal_ascii.
// ----------------------------------------------------------------------------
package sida_pkg;

  localparam int unsigned ValueW        = 32;
  localparam int unsigned NDigits       = 10;
  localparam int unsigned BcdW          = 4 * NDigits;
  localparam int unsigned StepsPerStage = 8;
  localparam int unsigned DdStages      = ValueW / StepsPerStage;
  localparam int unsigned CharW         = 8;
  localparam int unsigned CountW        = 4;

  localparam logic [CharW-1:0] AsciiZero  = 8'd48;
  localparam logic [CharW-1:0] AsciiMinus = 8'd45;

  typedef struct packed {
    logic              neg;
    logic [BcdW-1:0]   bcd;
    logic [ValueW-1:0] bin;
  } dd_t;

  // several double dabble steps: correct every digit, then shift one bit in
  function automatic dd_t dd_steps(dd_t x);
    dd_t r;
    r = x;
    for (int s = 0; s < StepsPerStage; s++) begin
      for (int d = 0; d < NDigits; d++) begin
        if (r.bcd[4*d +: 4] >= 4'd5) begin
          r.bcd[4*d +: 4] = r.bcd[4*d +: 4] + 4'd3;
        end
      end
      {r.bcd, r.bin} = {r.bcd, r.bin} << 1;
    end
    return r;
  endfunction

endpackage

[hdl/signed_int_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Turns a signed 32-bit integer into its decimal ASCII text, one character
// per output beat, most significant first.
// ----------------------------------------------------------------------------
// Usage:
//   Input: value_i is taken at a rising edge where start_i is high and
//   busy_o is low.
//   Output: one character per beat on char_code_o, is_last_o and
//   char_count_o, marked by valid_o for exactly one cycle. The receiver
//   cannot hold beats off.
//   Pipeline: input capture with sign and magnitude, four binary to BCD
//   stages of eight shift-and-add-3 steps each, a digit count and align
//   stage, then a serialiser that sends one character per cycle.
//   Path: the first beat passes the capture register, the BCD stage
//   registers, the count and align register and the serialiser register.
//   Flow: a value has 1 to 11 characters; the serialiser holds it until its
//   last character is sent and back-pressures the pipeline through busy_o,
//   which goes high once all the earlier stages hold values.
//   Reset: all stage valid bits and the serialiser clear at once; no beat
//   is sent and busy_o is low after reset.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic signed [sida_pkg::ValueW-1:0] value_i,
  output logic                            valid_o,
  output logic [sida_pkg::CharW-1:0]      char_code_o,
  output logic                            is_last_o,
  output logic [sida_pkg::CountW-1:0]     char_count_o
);

  localparam logic [sida_pkg::CountW-1:0] NDigitsC = sida_pkg::CountW'(sida_pkg::NDigits);

  // capture plus binary to bcd stages
  logic          dd_v_q [0:sida_pkg::DdStages];
  sida_pkg::dd_t dd_q   [0:sida_pkg::DdStages];
  logic          dd_rdy [0:sida_pkg::DdStages];

  // count and align stage
  logic                          cnt_v_q;
  logic                          cnt_neg_q;
  logic [sida_pkg::BcdW-1:0]     cnt_digits_q;
  logic [sida_pkg::CountW-1:0]   cnt_total_q;
  logic                          cnt_rdy;
  logic [sida_pkg::CountW-1:0]   nd;
  logic [5:0]                    align_sh;
  sida_pkg::dd_t                 dd_last;

  // serialiser
  logic                          ser_v_q;
  logic                          ser_sign_q;
  logic [sida_pkg::BcdW-1:0]     ser_digits_q;
  logic [sida_pkg::CountW-1:0]   ser_left_q;
  logic [sida_pkg::CountW-1:0]   ser_total_q;
  logic                          ser_rdy;

  logic                          accept;
  logic                          in_neg;
  logic [sida_pkg::ValueW-1:0]   in_mag;

  assign ser_rdy = !ser_v_q || (ser_left_q == 4'd1);
  assign cnt_rdy = !cnt_v_q || ser_rdy;

  always_comb begin
    dd_rdy[sida_pkg::DdStages] = !dd_v_q[sida_pkg::DdStages] || cnt_rdy;
    for (int k = sida_pkg::DdStages - 1; k >= 0; k--) begin
      dd_rdy[k] = !dd_v_q[k] || dd_rdy[k+1];
    end
  end

  assign busy_o = !dd_rdy[0];
  assign accept = start_i && !busy_o;

  assign in_neg = value_i[sida_pkg::ValueW-1];
  assign in_mag = in_neg ? (~value_i + 1'b1) : value_i;

  // leading digit position, zero still gives one digit
  assign dd_last = dd_q[sida_pkg::DdStages];
  always_comb begin
    nd = 4'd1;
    for (int d = 0; d < sida_pkg::NDigits; d++) begin
      if (dd_last.bcd[4*d +: 4] != 4'd0) begin
        nd = sida_pkg::CountW'(d + 1);
      end
    end
    align_sh = {NDigitsC - nd, 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= sida_pkg::DdStages; k++) begin
        dd_v_q[k] <= 1'b0;
      end
      cnt_v_q <= 1'b0;
      ser_v_q <= 1'b0;
    end else begin
      if (dd_rdy[0]) begin
        dd_v_q[0] <= accept;
      end
      for (int k = 1; k <= sida_pkg::DdStages; k++) begin
        if (dd_rdy[k]) begin
          dd_v_q[k] <= dd_v_q[k-1];
        end
      end
      if (cnt_rdy) begin
        cnt_v_q <= dd_v_q[sida_pkg::DdStages];
      end
      if (ser_rdy) begin
        ser_v_q <= cnt_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dd_rdy[0]) begin
      dd_q[0] <= '{neg: in_neg, bcd: '0, bin: in_mag};
    end
    for (int k = 1; k <= sida_pkg::DdStages; k++) begin
      if (dd_rdy[k]) begin
        dd_q[k] <= sida_pkg::dd_steps(dd_q[k-1]);
      end
    end
    if (cnt_rdy) begin
      cnt_neg_q    <= dd_last.neg;
      cnt_digits_q <= dd_last.bcd << align_sh;
      cnt_total_q  <= nd + sida_pkg::CountW'(dd_last.neg);
    end
    if (ser_rdy) begin
      ser_sign_q   <= cnt_neg_q;
      ser_digits_q <= cnt_digits_q;
      ser_left_q   <= cnt_total_q;
      ser_total_q  <= cnt_total_q;
    end else begin
      if (ser_sign_q) begin
        ser_sign_q <= 1'b0;
      end else begin
        ser_digits_q <= ser_digits_q << 4;
      end
      ser_left_q <= ser_left_q - 4'd1;
    end
  end

  assign valid_o      = ser_v_q;
  assign char_code_o  = ser_sign_q ? sida_pkg::AsciiMinus
                      : sida_pkg::AsciiZero + {4'd0, ser_digits_q[sida_pkg::BcdW-1 -: 4]};
  assign is_last_o    = (ser_left_q == 4'd1);
  assign char_count_o = ser_total_q;

endmodule

[tb/tb_signed_int_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii
// Self-checking bench for the signed integer to decimal ASCII converter.
// A model in the bench predicts the character beats for each accepted value.
// A checker compares every output beat with the oldest prediction. Stimulus
// is a directed set of edge values followed by random values that cover
// every digit count and both signs. Sender gaps are random or absent.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii;

  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    logic [sida_pkg::CharW-1:0]  code;
    logic                        last;
    logic [sida_pkg::CountW-1:0] count;
  } char_beat_t;

  logic                               clk_i        = 1'b0;
  logic                               rst_ni       = 1'b0;
  logic                               start_i      = 1'b0;
  logic signed [sida_pkg::ValueW-1:0] value_i      = '0;
  logic                               busy_o;
  logic                               valid_o;
  logic [sida_pkg::CharW-1:0]         char_code_o;
  logic                               is_last_o;
  logic [sida_pkg::CountW-1:0]        char_count_o;

  char_beat_t  expected_chars[$];
  int unsigned error_count  = 0;
  int unsigned values_sent  = 0;
  int unsigned beats_seen   = 0;
  int unsigned cycle_count  = 0;
  int unsigned idle_pct     = 19;

  signed_int_to_decimal_ascii dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .value_i      (value_i),
    .valid_o      (valid_o),
    .char_code_o  (char_code_o),
    .is_last_o    (is_last_o),
    .char_count_o (char_count_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: run stopped after %0d cycles", $time, cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // decimal text of one value, sign first, pushed as expected beats
  function automatic void predict_text(logic [sida_pkg::ValueW-1:0] v);
    logic                        neg;
    logic [sida_pkg::ValueW-1:0] mag;
    logic [3:0]                  digits[sida_pkg::NDigits];
    int                          nd;
    logic [sida_pkg::CountW-1:0] total;
    char_beat_t                  b;
    neg = v[sida_pkg::ValueW-1];
    mag = neg ? (~v + 1'b1) : v;
    nd  = 0;
    do begin
      digits[nd] = 4'(mag % 10);
      mag        = mag / 10;
      nd++;
    end while (mag != 0 && nd < sida_pkg::NDigits);
    total = sida_pkg::CountW'(nd + (neg ? 1 : 0));
    if (neg) begin
      b = '{code: sida_pkg::AsciiMinus, last: 1'b0, count: total};
      expected_chars.push_back(b);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      b = '{code: sida_pkg::AsciiZero + sida_pkg::CharW'(digits[i]), last: (i == 0),
            count: total};
      expected_chars.push_back(b);
    end
  endfunction

  always @(posedge clk_i) begin
    char_beat_t exp_beat;
    if (rst_ni && valid_o) begin
      beats_seen++;
      if (expected_chars.size() == 0) begin
        $display("%0t: beat with nothing expected, actual code %0d last %0b count %0d",
                 $time, char_code_o, is_last_o, char_count_o);
        error_count++;
      end else begin
        exp_beat = expected_chars.pop_front();
        if (char_code_o !== exp_beat.code) begin
          $display("%0t: char_code expected %0d actual %0d",
                   $time, exp_beat.code, char_code_o);
          error_count++;
        end
        if (is_last_o !== exp_beat.last) begin
          $display("%0t: is_last expected %0b actual %0b",
                   $time, exp_beat.last, is_last_o);
          error_count++;
        end
        if (char_count_o !== exp_beat.count) begin
          $display("%0t: char_count expected %0d actual %0d",
                   $time, exp_beat.count, char_count_o);
          error_count++;
        end
      end
    end
  end

  // one value beat, sometimes with a random gap ahead of it
  task automatic send_value(input logic [sida_pkg::ValueW-1:0] v);
    int unsigned gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(4, 1);
      repeat (gap) begin
        @(negedge clk_i);
        start_i <= 1'b0;
        value_i <= $urandom;
      end
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (busy_o);
    predict_text(v);
    values_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
  endtask

  // random value of random digit count and sign, sometimes fully random bits
  function automatic logic [sida_pkg::ValueW-1:0] pick_value();
    int unsigned n;
    int unsigned lo;
    int unsigned hi;
    int unsigned mag;
    if ($urandom_range(7) == 0) return $urandom;
    n  = $urandom_range(sida_pkg::NDigits, 1);
    lo = 1;
    for (int i = 1; i < n; i++) lo = lo * 10;
    hi = (n == sida_pkg::NDigits) ? 32'h7fff_ffff : lo * 10 - 1;
    if (n == 1) lo = 0;
    mag = $urandom_range(hi, lo);
    return $urandom_range(1) ? (~mag + 1) : mag;
  endfunction

  task automatic test_edge_values();
    logic [sida_pkg::ValueW-1:0] vals[] = '{
      32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd9, -32'sd10, 32'd99, 32'd100,
      -32'sd100, 32'd12345, -32'sd54321, 32'd999999999, 32'd1000000000,
      -32'sd999999999, -32'sd1000000000, 32'h7fff_ffff, 32'h8000_0000,
      32'h8000_0001, 32'h7fff_fffe, 32'hffff_fff6, 32'h0000_ffff,
      32'hffff_0000, 32'h5555_5555, 32'haaaa_aaaa
    };
    foreach (vals[i]) send_value(vals[i]);
  endtask

  task automatic test_drain_between_values();
    for (int i = 0; i < 8; i++) begin
      wait_drained();
      send_value(pick_value());
    end
  endtask

  task automatic test_random_with_gaps();
    idle_pct = 19;
    for (int i = 0; i < 230; i++) send_value(pick_value());
  endtask

  task automatic test_back_to_back();
    idle_pct = 0;
    for (int i = 0; i < 200; i++) send_value(pick_value());
    idle_pct = 19;
  endtask

  initial begin
    int unsigned wait_cycles;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_edge_values();
    test_drain_between_values();
    test_random_with_gaps();
    test_back_to_back();

    @(negedge clk_i);
    start_i <= 1'b0;
    wait_cycles = 0;
    while (expected_chars.size() != 0 && wait_cycles < 2000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (20) @(posedge clk_i);
    if (expected_chars.size() != 0) begin
      $display("%0t: %0d expected beats never arrived", $time, expected_chars.size());
      error_count++;
    end

    $display("covered %0d values (edge cases, drained, gapped and back to back)",
             values_sent);
    $display("checked %0d character beats, %0d errors", beats_seen, error_count);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[signed_int_to_decimal_ascii.f]
hdl/sida_pkg.sv
hdl/signed_int_to_decimal_ascii.sv
tb/tb_signed_int_to_decimal_ascii.sv
